/* rtl/core/assert_macros.svh */
// Assertion macros for the checker file of this project.
// Each macro samples on the rising edge of clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled edge.
`define GJDC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that must never be seen at a sampled edge.
`define GJDC_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* rtl/core/gjdc_pkg.sv */
// ----------------------------------------------------------------------------
// gjdc_pkg: shared types and constants of the calendar converter
// Field widths, operation codes, day number bounds and the reciprocal
// constants that replace division by fixed divisors.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gjdc_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned YEAR_W   = 14;
  localparam int unsigned JDN_W    = 23;
  localparam int unsigned OFFSET_W = 23;
  localparam int unsigned NUMBER_W = 24;

  // Number of register stages from the request to the result register.
  localparam int unsigned PIPE_DEPTH = 12;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TO_DAY_NUMBER = 2'd0,
    FUNC_TO_DATE       = 2'd1,
    FUNC_DIFF          = 2'd2,
    FUNC_SUB_DAYS      = 2'd3
  } func_e;

  // Day numbers of 1 January of year 1 and 31 December of year 9999.
  localparam int JDN_FIRST = 1721426;
  localparam int JDN_LAST  = 5373484;

  // Constants of the day number formula and of the inverse algorithm.
  localparam int unsigned YEAR_BIAS   = 4800;
  localparam int unsigned JDN_BIAS    = 32045;
  localparam int unsigned DAYS_YEAR   = 365;
  localparam int unsigned CYCLE_BIAS  = 274277;
  localparam int unsigned F_BIAS      = 1401;
  localparam int unsigned F_CORR      = 38;
  localparam int unsigned YEAR_BASE   = 4716;

  // Divisors and the matching reciprocals. With a dividend below 2**XW and
  // a divisor at most 2**DW, shift XW + DW with a rounded-up reciprocal
  // gives the exact floor quotient.
  localparam longint unsigned DIV_CENT   = 100;
  localparam longint unsigned DIV_QCENT  = 400;
  localparam longint unsigned DIV_CYCLE  = 146097;
  localparam longint unsigned DIV_QYEAR  = 1461;
  localparam longint unsigned DIV_MONTHS = 153;
  localparam longint unsigned DIV_DAY    = 5;

  localparam int unsigned SH_CENT   = 15 + 7;
  localparam int unsigned SH_QCENT  = 15 + 9;
  localparam int unsigned SH_CYCLE  = 25 + 18;
  localparam int unsigned SH_QYEAR  = 25 + 11;
  localparam int unsigned SH_MONTHS = 11 + 8;
  localparam int unsigned SH_DAY    = 8 + 3;

  localparam longint unsigned RECIP_CENT =
    ((64'd1 << SH_CENT) + DIV_CENT - 64'd1) / DIV_CENT;
  localparam longint unsigned RECIP_QCENT =
    ((64'd1 << SH_QCENT) + DIV_QCENT - 64'd1) / DIV_QCENT;
  localparam longint unsigned RECIP_CYCLE =
    ((64'd1 << SH_CYCLE) + DIV_CYCLE - 64'd1) / DIV_CYCLE;
  localparam longint unsigned RECIP_QYEAR =
    ((64'd1 << SH_QYEAR) + DIV_QYEAR - 64'd1) / DIV_QYEAR;
  localparam longint unsigned RECIP_MONTHS =
    ((64'd1 << SH_MONTHS) + DIV_MONTHS - 64'd1) / DIV_MONTHS;
  localparam longint unsigned RECIP_DAY =
    ((64'd1 << SH_DAY) + DIV_DAY - 64'd1) / DIV_DAY;

  // Days before the shifted month, (153 * ms + 2) / 5, for a March-based
  // month index.
  function automatic logic [8:0] month_start_days(input logic [3:0] ms);
    logic [8:0] days;
    case (ms)
      4'd0:    days = 9'd0;
      4'd1:    days = 9'd31;
      4'd2:    days = 9'd61;
      4'd3:    days = 9'd92;
      4'd4:    days = 9'd122;
      4'd5:    days = 9'd153;
      4'd6:    days = 9'd184;
      4'd7:    days = 9'd214;
      4'd8:    days = 9'd245;
      4'd9:    days = 9'd275;
      4'd10:   days = 9'd306;
      4'd11:   days = 9'd337;
      4'd12:   days = 9'd367;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/gjdc_req_if.sv */
// ----------------------------------------------------------------------------
// gjdc_req_if: request channel of the calendar converter
// Valid/ready handshake with the operation code and both dates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gjdc_req_if;
  logic                                   valid;
  logic                                   ready;
  logic        [gjdc_pkg::FUNC_W-1:0]     func;
  logic        [gjdc_pkg::DAY_W-1:0]      day;
  logic        [gjdc_pkg::MONTH_W-1:0]    month;
  logic        [gjdc_pkg::YEAR_W-1:0]     year;
  logic        [gjdc_pkg::DAY_W-1:0]      other_day;
  logic        [gjdc_pkg::MONTH_W-1:0]    other_month;
  logic        [gjdc_pkg::YEAR_W-1:0]     other_year;
  logic        [gjdc_pkg::JDN_W-1:0]      day_number;
  logic signed [gjdc_pkg::OFFSET_W-1:0]   day_offset;

  modport source (
    output valid, func, day, month, year, other_day, other_month, other_year,
           day_number, day_offset,
    input  ready
  );

  modport sink (
    input  valid, func, day, month, year, other_day, other_month, other_year,
           day_number, day_offset,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/gjdc_rsp_if.sv */
// ----------------------------------------------------------------------------
// gjdc_rsp_if: result channel of the calendar converter
// Valid/ready handshake with the day number and the date result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gjdc_rsp_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [gjdc_pkg::NUMBER_W-1:0]   number_result;
  logic        [gjdc_pkg::DAY_W-1:0]      out_day;
  logic        [gjdc_pkg::MONTH_W-1:0]    out_month;
  logic        [gjdc_pkg::YEAR_W-1:0]     out_year;
  logic                                   out_of_range;

  modport source (
    output valid, number_result, out_day, out_month, out_year, out_of_range,
    input  ready
  );

  modport sink (
    input  valid, number_result, out_day, out_month, out_year, out_of_range,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/core/gregorian_julian_day_converter.sv */
// Each accepted request passes through the stage registers in order; its result shows on the
// output from the last one, which is the output register.
// Throughput: one transaction per cycle while the output is not stalled; every stage has its own valid bit.
// A stalled output holds its stage while earlier stages keep filling bubbles.
// Reset (rst_ni low, asynchronous) clears all valid bits; no clearing pass.
// ----------------------------------------------------------------------------
// gregorian_julian_day_converter: proleptic Gregorian day number unit
// Converts dates to Julian day numbers and back, forms day differences and
// subtracts day offsets, in a twelve-stage pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gregorian_julian_day_converter (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gjdc_req_if.sink    req_i,
  gjdc_rsp_if.source  rsp_o
);

  localparam int unsigned Depth = gjdc_pkg::PIPE_DEPTH;

  // Front part of the day number formula for one date: the March-based
  // year and the day of month plus the days before the month.
  typedef struct packed {
    logic [14:0] ys;
    logic [9:0]  dt;
  } front_t;

  // Everything one transaction carries through the pipeline. Each stage
  // fills in its own fields and copies the rest; unused fields fall away
  // in synthesis.
  typedef struct packed {
    gjdc_pkg::func_e                      func;
    logic        [gjdc_pkg::JDN_W-1:0]    day_number;
    logic signed [gjdc_pkg::OFFSET_W-1:0] day_offset;
    logic        [14:0]                   ys1;
    logic        [14:0]                   ys2;
    logic        [9:0]                    dt1;
    logic        [9:0]                    dt2;
    logic        [23:0]                   p365_1;
    logic        [23:0]                   p365_2;
    logic        [7:0]                    qcent1;
    logic        [7:0]                    qcent2;
    logic        [5:0]                    qqcent1;
    logic        [5:0]                    qqcent2;
    logic        [23:0]                   jdn1;
    logic        [23:0]                   jdn2;
    logic signed [gjdc_pkg::NUMBER_W-1:0] number;
    logic signed [24:0]                   target;
    logic                                 is_date;
    logic                                 flag;
    logic        [24:0]                   x;
    logic        [7:0]                    qcyc;
    logic        [24:0]                   e;
    logic        [13:0]                   q;
    logic        [10:0]                   r;
    logic        [10:0]                   h;
    logic        [3:0]                    hq;
    logic        [7:0]                    hr;
    logic        [3:0]                    mm;
    logic        [4:0]                    dd;
    logic        [13:0]                   yy;
  } stage_t;

  // Months 0 to 2 count as the tail of the previous year, months 3 and up
  // as the current one, exactly as the signed month term of the formula.
  function automatic front_t date_front(input logic [4:0]  d,
                                        input logic [3:0]  m,
                                        input logic [13:0] y);
    front_t     f;
    logic       a;
    logic [3:0] ms;
    a    = (m <= 4'd2);
    ms   = a ? (m + 4'd9) : (m - 4'd3);
    f.ys = 15'(y) + 15'(gjdc_pkg::YEAR_BIAS) - 15'(a);
    f.dt = 10'(d) + 10'(gjdc_pkg::month_start_days(ms));
    return f;
  endfunction

  stage_t             stg_d [Depth];
  stage_t             stg_q [Depth];
  logic [Depth-1:0]   vld_q;
  logic [Depth-1:0]   vld_in;
  logic [Depth-1:0]   adv;

  // ---------------------------------------------------------------------------
  // Flow control. A stage loads when it is empty or when everything after it
  // moves, so bubbles close up behind a stalled result.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [Depth-1:0] mask;
    for (int k = 0; k < Depth; k++) begin
      mask   = {Depth{1'b1}} << k;
      adv[k] = rsp_o.ready || (|(~vld_q & mask));
    end
  end

  assign vld_in      = {vld_q[Depth-2:0], req_i.valid};
  assign req_i.ready = adv[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < Depth; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < Depth; k++) begin
      if (adv[k]) begin
        stg_q[k] <= stg_d[k];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage logic. A stage may hold more than one multiplier or wide add; stage 2 holds six multipliers.
  // ---------------------------------------------------------------------------
  always_comb begin
    stage_t      s;
    front_t      fr1;
    front_t      fr2;
    logic [31:0] m_cent1;
    logic [31:0] m_cent2;
    logic [31:0] m_qcent1;
    logic [31:0] m_qcent2;
    logic [50:0] m_cyc;
    logic [50:0] m_qyr;
    logic [22:0] m_mon;
    logic [16:0] m_day;
    logic [22:0] f_v;
    logic [8:0]  g_v;
    logic [3:0]  mon_v;

    // Stage 1: March-based year and month for both dates.
    s            = '0;
    s.func       = gjdc_pkg::func_e'(req_i.func);
    s.day_number = req_i.day_number;
    s.day_offset = req_i.day_offset;
    fr1          = date_front(req_i.day, req_i.month, req_i.year);
    fr2          = date_front(req_i.other_day, req_i.other_month, req_i.other_year);
    s.ys1        = fr1.ys;
    s.dt1        = fr1.dt;
    s.ys2        = fr2.ys;
    s.dt2        = fr2.dt;
    stg_d[0]     = s;

    // Stage 2: year products; century and quad-century counts by reciprocal.
    s         = stg_q[0];
    s.p365_1  = 24'(s.ys1) * 24'(gjdc_pkg::DAYS_YEAR);
    s.p365_2  = 24'(s.ys2) * 24'(gjdc_pkg::DAYS_YEAR);
    m_cent1   = 32'(s.ys1) * 32'(gjdc_pkg::RECIP_CENT);
    m_cent2   = 32'(s.ys2) * 32'(gjdc_pkg::RECIP_CENT);
    m_qcent1  = 32'(s.ys1) * 32'(gjdc_pkg::RECIP_QCENT);
    m_qcent2  = 32'(s.ys2) * 32'(gjdc_pkg::RECIP_QCENT);
    s.qcent1  = 8'(m_cent1 >> gjdc_pkg::SH_CENT);
    s.qcent2  = 8'(m_cent2 >> gjdc_pkg::SH_CENT);
    s.qqcent1 = 6'(m_qcent1 >> gjdc_pkg::SH_QCENT);
    s.qqcent2 = 6'(m_qcent2 >> gjdc_pkg::SH_QCENT);
    stg_d[1]  = s;

    // Stage 3: day numbers of both dates. The true values are positive and
    // below 2**23, so modulo arithmetic on 24 bits is exact.
    s        = stg_q[1];
    s.jdn1   = 24'(s.dt1) + s.p365_1 + 24'(s.ys1 >> 2) - 24'(s.qcent1)
             + 24'(s.qqcent1) - 24'(gjdc_pkg::JDN_BIAS);
    s.jdn2   = 24'(s.dt2) + s.p365_2 + 24'(s.ys2 >> 2) - 24'(s.qcent2)
             + 24'(s.qqcent2) - 24'(gjdc_pkg::JDN_BIAS);
    stg_d[2] = s;

    // Stage 4: the number result, and the day number to turn into a date.
    s = stg_q[2];
    case (s.func)
      gjdc_pkg::FUNC_TO_DAY_NUMBER: s.number = $signed(s.jdn1);
      gjdc_pkg::FUNC_DIFF:          s.number = $signed(s.jdn2 - s.jdn1);
      default:                      s.number = '0;
    endcase
    if (s.func == gjdc_pkg::FUNC_TO_DATE) begin
      s.target = $signed({2'b00, s.day_number});
    end else begin
      s.target = $signed({1'b0, s.jdn1}) - 25'(s.day_offset);
    end
    s.is_date = (s.func == gjdc_pkg::FUNC_TO_DATE) || (s.func == gjdc_pkg::FUNC_SUB_DAYS);
    stg_d[3]  = s;

    // Stage 5: range check; operand of the 400-year cycle count.
    s        = stg_q[3];
    s.flag   = s.is_date && ((s.target < 25'(gjdc_pkg::JDN_FIRST)) ||
                             (s.target > 25'(gjdc_pkg::JDN_LAST)));
    s.x      = {s.target[22:0], 2'b00} + 25'(gjdc_pkg::CYCLE_BIAS);
    stg_d[4] = s;

    // Stage 6: (4j + 274277) / 146097.
    s        = stg_q[4];
    m_cyc    = 51'(s.x) * 51'(gjdc_pkg::RECIP_CYCLE);
    s.qcyc   = 8'(m_cyc >> gjdc_pkg::SH_CYCLE);
    stg_d[5] = s;

    // Stage 7: f and e = 4f + 3.
    s        = stg_q[5];
    f_v      = s.target[22:0] + 23'(gjdc_pkg::F_BIAS)
             + 23'((10'(s.qcyc) * 10'd3) >> 2) - 23'(gjdc_pkg::F_CORR);
    s.e      = {f_v, 2'b11};
    stg_d[6] = s;

    // Stage 8: e / 1461.
    s        = stg_q[6];
    m_qyr    = 51'(s.e) * 51'(gjdc_pkg::RECIP_QYEAR);
    s.q      = 14'(m_qyr >> gjdc_pkg::SH_QYEAR);
    stg_d[7] = s;

    // Stage 9: e % 1461.
    s        = stg_q[7];
    s.r      = 11'(s.e - 25'(s.q) * 25'(gjdc_pkg::DIV_QYEAR));
    stg_d[8] = s;

    // Stage 10: h = 5g + 2 and h / 153.
    s        = stg_q[8];
    g_v      = 9'(s.r >> 2);
    s.h      = 11'(g_v) * 11'd5 + 11'd2;
    m_mon    = 23'(s.h) * 23'(gjdc_pkg::RECIP_MONTHS);
    s.hq     = 4'(m_mon >> gjdc_pkg::SH_MONTHS);
    stg_d[9] = s;

    // Stage 11: h % 153 and the month, with the wrap at twelve.
    s     = stg_q[9];
    s.hr  = 8'(s.h - 11'(s.hq) * 11'(gjdc_pkg::DIV_MONTHS));
    mon_v = s.hq + 4'd2;
    if (mon_v >= 4'd12) begin
      mon_v = mon_v - 4'd12;
    end
    s.mm      = mon_v + 4'd1;
    stg_d[10] = s;

    // Stage 12: day and year; date fields clear where no date is due.
    s     = stg_q[10];
    m_day = 17'(s.hr) * 17'(gjdc_pkg::RECIP_DAY);
    s.dd  = 5'(m_day >> gjdc_pkg::SH_DAY) + 5'd1;
    s.yy  = s.q - 14'(gjdc_pkg::YEAR_BASE) + 14'(s.mm <= 4'd2);
    if (!s.is_date || s.flag) begin
      s.dd = '0;
      s.mm = '0;
      s.yy = '0;
    end
    stg_d[11] = s;
  end

  // ---------------------------------------------------------------------------
  // The last stage is the output register.
  // ---------------------------------------------------------------------------
  assign rsp_o.valid         = vld_q[Depth-1];
  assign rsp_o.number_result = stg_q[Depth-1].number;
  assign rsp_o.out_day       = stg_q[Depth-1].dd;
  assign rsp_o.out_month     = stg_q[Depth-1].mm;
  assign rsp_o.out_year      = stg_q[Depth-1].yy;
  assign rsp_o.out_of_range  = stg_q[Depth-1].flag;

endmodule

`default_nettype wire

/* rtl/core/gjdc_checker.sv */
// ----------------------------------------------------------------------------
// gjdc_checker: port-level checks of the calendar converter
// Tracks transactions in flight and checks flow control on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gjdc_checker (
  input wire logic                                  clk_i,
  input wire logic                                  rst_ni,
  input wire logic                                  req_valid_i,
  input wire logic                                  req_ready_i,
  input wire logic                                  rsp_valid_i,
  input wire logic                                  rsp_ready_i,
  input wire logic signed [gjdc_pkg::NUMBER_W-1:0]  rsp_number_result_i,
  input wire logic        [gjdc_pkg::DAY_W-1:0]     rsp_out_day_i,
  input wire logic        [gjdc_pkg::MONTH_W-1:0]   rsp_out_month_i,
  input wire logic        [gjdc_pkg::YEAR_W-1:0]    rsp_out_year_i,
  input wire logic                                  rsp_out_of_range_i
);

  localparam int unsigned CntW  = $clog2(gjdc_pkg::PIPE_DEPTH + 1);
  localparam int unsigned WordW = 2 + gjdc_pkg::NUMBER_W + gjdc_pkg::DAY_W
                                + gjdc_pkg::MONTH_W + gjdc_pkg::YEAR_W;

  logic [CntW-1:0]  cnt_d;
  logic [CntW-1:0]  cnt_q;
  logic             rsp_stalled;
  logic [WordW-1:0] rsp_word;

  // Transactions accepted but not yet delivered.
  assign cnt_d = cnt_q + CntW'(req_valid_i && req_ready_i)
                       - CntW'(rsp_valid_i && rsp_ready_i);

  // A result that waits, and everything that must hold while it waits.
  assign rsp_stalled = rsp_valid_i && !rsp_ready_i;
  assign rsp_word    = {rsp_valid_i, rsp_number_result_i, rsp_out_day_i, rsp_out_month_i,
                        rsp_out_year_i, rsp_out_of_range_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `GJDC_ASSERT(a_rsp_hold, rsp_stalled |=> $stable(rsp_word), "stalled result changed")
  `GJDC_ASSERT(a_req_backpressure, !req_ready_i |-> rsp_stalled, "refused without a stall")
  `GJDC_ASSERT(a_no_phantom, cnt_q == '0 |-> !rsp_valid_i, "result with nothing in flight")
  `GJDC_ASSERT_NEVER(a_depth, cnt_q > CntW'(gjdc_pkg::PIPE_DEPTH), "too many in flight")

endmodule

bind gregorian_julian_day_converter gjdc_checker u_gjdc_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .req_valid_i         (req_i.valid),
  .req_ready_i         (req_i.ready),
  .rsp_valid_i         (rsp_o.valid),
  .rsp_ready_i         (rsp_o.ready),
  .rsp_number_result_i (rsp_o.number_result),
  .rsp_out_day_i       (rsp_o.out_day),
  .rsp_out_month_i     (rsp_o.out_month),
  .rsp_out_year_i      (rsp_o.out_year),
  .rsp_out_of_range_i  (rsp_o.out_of_range)
);

`default_nettype wire
